[hdl/bdcm_pkg.sv]
// Shared types, constants and helpers of the block-diagonal complex mat-vec.
`default_nettype none
package bdcm_pkg;

  localparam int ACC_W      = 64;
  localparam int FRAC_SHIFT = 30;
  localparam int DEG_OUT_W  = 4;
  localparam int ORD_OUT_W  = 5;
  localparam int TOP_W      = 4;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_ELEM = 1'b1
  } func_t;

  // Per-element tag that travels with an item down the datapath.
  typedef struct packed {
    logic                 row_end;
    logic                 last;
    logic [DEG_OUT_W-1:0] degree;
    logic [ORD_OUT_W-1:0] order;
  } bdcm_tag_t;

  // Signed add clamped at the accumulator limits.
  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W:0] sum;
    logic signed [ACC_W-1:0] res;
    sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      res = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      res = sum[ACC_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[hdl/bdcm_ctrl.sv]
// Sequencing counters, load pointer and store address generation.
`default_nettype none
module bdcm_ctrl
  import bdcm_pkg::*;
#(
  parameter int MAX_DEGREE = 15
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [TOP_W-1:0] cfg_wr_data,
  input  wire logic             accept,
  input  wire logic             func,
  output logic                  wr_en,
  output logic [(((MAX_DEGREE+1)*(MAX_DEGREE+1)) > 1 ?
                 $clog2((MAX_DEGREE+1)*(MAX_DEGREE+1)) : 1)-1:0] wr_addr,
  output logic [(((MAX_DEGREE+1)*(MAX_DEGREE+1)) > 1 ?
                 $clog2((MAX_DEGREE+1)*(MAX_DEGREE+1)) : 1)-1:0] rd_addr,
  output bdcm_tag_t             tag
);

  localparam int STORE_DEPTH = (MAX_DEGREE + 1) * (MAX_DEGREE + 1);
  localparam int ADDR_W      = STORE_DEPTH > 1 ? $clog2(STORE_DEPTH) : 1;
  localparam int LP_W        = $clog2(STORE_DEPTH + 1);
  localparam int DEG_W       = $clog2(MAX_DEGREE + 2);
  localparam int IDX_W       = $clog2(2 * MAX_DEGREE + 2);

  logic [TOP_W-1:0]  top_degree;
  logic [LP_W-1:0]   load_pointer;
  logic [DEG_W-1:0]  degree_count;
  logic [IDX_W-1:0]  row_count;
  logic [IDX_W-1:0]  col_count;
  logic [ADDR_W-1:0] block_base;

  logic [7:0]        top_eff;
  logic [11:0]       load_count;
  logic [IDX_W-1:0]  span_last;
  logic              is_elem;
  logic              row_end;
  logic              block_end;
  logic              pass_end;

  always_comb begin
    top_eff    = (8'(top_degree) > 8'(MAX_DEGREE)) ? 8'(MAX_DEGREE) : 8'(top_degree);
    load_count = (12'(top_eff) + 12'd1) * (12'(top_eff) + 12'd1);
    span_last  = IDX_W'({degree_count, 1'b0});
    is_elem    = (func == FUNC_ELEM);
    row_end    = (col_count == span_last);
    block_end  = (row_count == span_last);
    pass_end   = row_end && block_end && (8'(degree_count) >= top_eff);

    wr_en   = accept && !is_elem && (12'(load_pointer) < load_count);
    wr_addr = load_pointer[ADDR_W-1:0];
    rd_addr = ADDR_W'(block_base + ADDR_W'(col_count));

    tag.row_end = row_end;
    tag.last    = pass_end;
    tag.degree  = DEG_OUT_W'(degree_count);
    tag.order   = ORD_OUT_W'(row_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_degree   <= '0;
      load_pointer <= '0;
      degree_count <= '0;
      row_count    <= '0;
      col_count    <= '0;
      block_base   <= '0;
    end else begin
      if (cfg_wr_en) begin
        top_degree <= cfg_wr_data;
      end
      if (wr_en) begin
        load_pointer <= load_pointer + LP_W'(1);
      end
      if (accept && is_elem) begin
        priority if (pass_end) begin
          load_pointer <= '0;
          degree_count <= '0;
          row_count    <= '0;
          col_count    <= '0;
          block_base   <= '0;
        end else if (row_end && block_end) begin
          // advance to the next degree block
          col_count    <= '0;
          row_count    <= '0;
          degree_count <= degree_count + DEG_W'(1);
          block_base   <= ADDR_W'(block_base + ADDR_W'(span_last) + ADDR_W'(1));
        end else if (row_end) begin
          col_count <= '0;
          row_count <= row_count + IDX_W'(1);
        end else begin
          col_count <= col_count + IDX_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

[hdl/bdcm_store.sv]
// Coefficient memory: one write port, one registered read port.
`default_nettype none
module bdcm_store #(
  parameter int DEPTH   = 256,
  parameter int ADDR_W  = 8,
  parameter int VALUE_W = 32
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [ADDR_W-1:0]         wr_addr,
  input  wire logic signed [VALUE_W-1:0] wr_re,
  input  wire logic signed [VALUE_W-1:0] wr_im,
  input  wire logic                      rd_en,
  input  wire logic [ADDR_W-1:0]         rd_addr,
  output logic signed [VALUE_W-1:0]      rd_re,
  output logic signed [VALUE_W-1:0]      rd_im
);

  logic [2*VALUE_W-1:0] mem [DEPTH];
  logic [2*VALUE_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_re, wr_im};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign rd_re = rd_data[2*VALUE_W-1:VALUE_W];
  assign rd_im = rd_data[VALUE_W-1:0];

endmodule
`default_nettype wire

[hdl/bdcm_mac.sv]
// Complex multiply stage and saturating row accumulator.
`default_nettype none
module bdcm_mac
  import bdcm_pkg::*;
#(
  parameter int VALUE_W = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      advance,
  input  wire logic                      elem_in,
  input  wire bdcm_tag_t                 tag_in,
  input  wire logic signed [VALUE_W-1:0] val_re,
  input  wire logic signed [VALUE_W-1:0] val_im,
  input  wire logic signed [VALUE_W-1:0] coef_re,
  input  wire logic signed [VALUE_W-1:0] coef_im,
  output logic                           res_valid,
  output bdcm_tag_t                      res_tag,
  output logic signed [ACC_W-1:0]        res_re,
  output logic signed [ACC_W-1:0]        res_im
);

  // stage 1: element operands, aligned with the store read data
  logic                      s1_valid;
  bdcm_tag_t                 s1_tag;
  logic signed [VALUE_W-1:0] s1_re;
  logic signed [VALUE_W-1:0] s1_im;

  // stage 2: partial products
  logic                      s2_valid;
  bdcm_tag_t                 s2_tag;
  logic signed [ACC_W-1:0]   p_rr;
  logic signed [ACC_W-1:0]   p_ii;
  logic signed [ACC_W-1:0]   p_ri;
  logic signed [ACC_W-1:0]   p_ir;

  logic signed [ACC_W-1:0]   acc_re;
  logic signed [ACC_W-1:0]   acc_im;
  logic signed [ACC_W-1:0]   acc_re_next;
  logic signed [ACC_W-1:0]   acc_im_next;

  always_comb begin
    acc_re_next = sat_add(sat_add(acc_re, p_rr), -p_ii);
    acc_im_next = sat_add(sat_add(acc_im, p_ri), p_ir);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_tag <= tag_in;
      s1_re  <= val_re;
      s1_im  <= val_im;
      s2_tag <= s1_tag;
      p_rr   <= ACC_W'(coef_re * s1_re);
      p_ii   <= ACC_W'(coef_im * s1_im);
      p_ri   <= ACC_W'(coef_re * s1_im);
      p_ir   <= ACC_W'(coef_im * s1_re);
      res_tag <= s2_tag;
      res_re  <= acc_re_next;
      res_im  <= acc_im_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
      acc_re    <= '0;
      acc_im    <= '0;
    end else if (advance) begin
      s1_valid  <= elem_in;
      s2_valid  <= s1_valid;
      res_valid <= s2_valid && s2_tag.row_end;
      if (s2_valid) begin
        // drop the running sum once a row closes
        acc_re <= s2_tag.row_end ? '0 : acc_re_next;
        acc_im <= s2_tag.row_end ? '0 : acc_im_next;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/bdcm_round.sv]
// Rounding, saturation and output register of row results.
`default_nettype none
module bdcm_round
  import bdcm_pkg::*;
#(
  parameter int VALUE_W = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    advance,
  input  wire logic                    res_valid,
  input  wire bdcm_tag_t               res_tag,
  input  wire logic signed [ACC_W-1:0] res_re,
  input  wire logic signed [ACC_W-1:0] res_im,
  output logic                         out_valid,
  output logic [31:0]                  sym_re,
  output logic [31:0]                  sym_im,
  output logic [DEG_OUT_W-1:0]         degree,
  output logic [ORD_OUT_W-1:0]         order_index,
  output logic                         last
);

  localparam int SH_W = ACC_W - FRAC_SHIFT;
  localparam logic signed [SH_W-1:0] HI = SH_W'((64'sd1 <<< (VALUE_W - 1)) - 64'sd1);
  localparam logic signed [SH_W-1:0] LO = -HI - SH_W'(1);
  localparam logic signed [ACC_W-1:0] BIAS = ACC_W'(64'sd1 <<< (FRAC_SHIFT - 1));

  function automatic logic [31:0] finish(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0]   biased;
    logic signed [SH_W-1:0]    r;
    logic signed [SH_W-1:0]    c;
    logic signed [VALUE_W-1:0] q;
    biased = sat_add(acc, BIAS);
    r = biased[ACC_W-1:FRAC_SHIFT];
    if (r > HI) begin
      c = HI;
    end else if (r < LO) begin
      c = LO;
    end else begin
      c = r;
    end
    q = c[VALUE_W-1:0];
    return 32'(q);
  endfunction

  always_ff @(posedge clk) begin
    if (advance) begin
      sym_re      <= finish(res_re);
      sym_im      <= finish(res_im);
      degree      <= res_tag.degree;
      order_index <= res_tag.order;
      last        <= res_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

endmodule
`default_nettype wire

[hdl/block_diagonal_complex_matvec.sv]
// Top level of the block-diagonal complex matrix-vector unit.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   input    | in_valid / in_ready   | func, value_re, value_im
//   result   | out_valid / out_ready | sym_re, sym_im, degree, order_index, last
//   config   | cfg_wr_en             | cfg_wr_data (top_degree)
//
// One item is accepted per cycle while in_ready is high. A result reaches the
// output register by these steps from the edge that accepts the item ending
// its row: store read at that edge, then complex multiply, accumulate, and
// round into the output register. Reset clears counters, load pointer and
// accumulators; the coefficient store is not cleared. While a result waits
// in the output register the whole pipeline holds and in_ready is low.
`default_nettype none
module block_diagonal_complex_matvec
  import bdcm_pkg::*;
#(
  parameter int MAX_DEGREE  = 15,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [TOP_W-1:0] cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             func,
  input  wire logic [31:0]      value_re,
  input  wire logic [31:0]      value_im,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           sym_re,
  output logic [31:0]           sym_im,
  output logic [DEG_OUT_W-1:0]  degree,
  output logic [ORD_OUT_W-1:0]  order_index,
  output logic                  last
);

  localparam int STORE_DEPTH = (MAX_DEGREE + 1) * (MAX_DEGREE + 1);
  localparam int ADDR_W      = STORE_DEPTH > 1 ? $clog2(STORE_DEPTH) : 1;

  logic                          advance;
  logic                          accept;
  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;
  logic [ADDR_W-1:0]             rd_addr;
  bdcm_tag_t                     tag;
  logic signed [VALUE_WIDTH-1:0] val_re;
  logic signed [VALUE_WIDTH-1:0] val_im;
  logic signed [VALUE_WIDTH-1:0] coef_re;
  logic signed [VALUE_WIDTH-1:0] coef_im;
  logic                          res_valid;
  bdcm_tag_t                     res_tag;
  logic signed [ACC_W-1:0]       res_re;
  logic signed [ACC_W-1:0]       res_im;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;
  assign val_re   = value_re[VALUE_WIDTH-1:0];
  assign val_im   = value_im[VALUE_WIDTH-1:0];

  bdcm_ctrl #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .func        (func),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .tag         (tag)
  );

  bdcm_store #(
    .DEPTH   (STORE_DEPTH),
    .ADDR_W  (ADDR_W),
    .VALUE_W (VALUE_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_re   (val_re),
    .wr_im   (val_im),
    .rd_en   (advance),
    .rd_addr (rd_addr),
    .rd_re   (coef_re),
    .rd_im   (coef_im)
  );

  bdcm_mac #(
    .VALUE_W (VALUE_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .elem_in   (accept && (func == FUNC_ELEM)),
    .tag_in    (tag),
    .val_re    (val_re),
    .val_im    (val_im),
    .coef_re   (coef_re),
    .coef_im   (coef_im),
    .res_valid (res_valid),
    .res_tag   (res_tag),
    .res_re    (res_re),
    .res_im    (res_im)
  );

  bdcm_round #(
    .VALUE_W (VALUE_WIDTH)
  ) u_round (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .res_valid   (res_valid),
    .res_tag     (res_tag),
    .res_re      (res_re),
    .res_im      (res_im),
    .out_valid   (out_valid),
    .sym_re      (sym_re),
    .sym_im      (sym_im),
    .degree      (degree),
    .order_index (order_index),
    .last        (last)
  );

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the block-diagonal complex matrix-vector unit.
`timescale 1ns / 1ps
module tb_top;
  import bdcm_pkg::*;

  localparam int RANDOM_ITEMS = 1450;
  localparam int HOLD_CYCLES  = 250;
  localparam int SETTLE       = 8;
  localparam int LIMIT_NS     = 1_000_000;
  localparam int STORE_SIZE   = 256;

  localparam logic signed [63:0] ACC_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN  = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] Q16_MAX  = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Q16_MIN  = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [63:0] HALF_LSB = 64'sh0000_0000_2000_0000;

  typedef struct packed {
    logic [31:0]          re;
    logic [31:0]          im;
    logic [DEG_OUT_W-1:0] deg;
    logic [ORD_OUT_W-1:0] ord;
    logic                 last;
  } row_sum_t;

  typedef struct {
    bit          is_cfg;
    func_t       f;
    logic [31:0] re;
    logic [31:0] im;
    bit          typed;
    row_sum_t    want;
  } plan_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [TOP_W-1:0]     cfg_wr_data;
  logic                 in_valid;
  logic                 in_ready;
  func_t                func;
  logic [31:0]          value_re;
  logic [31:0]          value_im;
  logic                 out_valid;
  logic                 out_ready;
  logic [31:0]          sym_re;
  logic [31:0]          sym_im;
  logic [DEG_OUT_W-1:0] degree;
  logic [ORD_OUT_W-1:0] order_index;
  logic                 last;

  block_diagonal_complex_matvec #(
    .MAX_DEGREE (15),
    .VALUE_WIDTH(32)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .value_re   (value_re),
    .value_im   (value_im),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sym_re     (sym_re),
    .sym_im     (sym_im),
    .degree     (degree),
    .order_index(order_index),
    .last       (last)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = ~clk;
  end

  // Shadow of the block: coefficient store, counters, accumulators.
  logic [31:0]        coef_re [STORE_SIZE];
  logic [31:0]        coef_im [STORE_SIZE];
  bit                 written [STORE_SIZE];
  int unsigned        ld_ptr   = 0;
  int unsigned        deg_cnt  = 0;
  int unsigned        row_cnt  = 0;
  int unsigned        col_cnt  = 0;
  int unsigned        base     = 0;
  int unsigned        top      = 0;
  logic signed [63:0] acc_re   = '0;
  logic signed [63:0] acc_im   = '0;
  bit                 pass_closed;

  row_sum_t  row_sums [$];
  plan_row_t plan [$];
  int        err_count       = 0;
  int        items_taken     = 0;
  int        effective_items = 0;
  int        burst_left      = 0;
  int        hold_mark       = 300;

  function automatic logic signed [63:0] acc_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64:63] == 2'b01) return ACC_MAX;
    if (s[64:63] == 2'b10) return ACC_MIN;
    return s[63:0];
  endfunction

  // Round half up from Q.46 to Q.16 and clamp to 32 bits.
  function automatic logic [31:0] to_q16(input logic signed [63:0] acc);
    logic signed [63:0] q;
    q = acc_add(acc, HALF_LSB) >>> 30;
    if (q > Q16_MAX) return 32'h7FFF_FFFF;
    if (q < Q16_MIN) return 32'h8000_0000;
    return q[31:0];
  endfunction

  function automatic void accumulate_item(input func_t f, input logic [31:0] re,
                                          input logic [31:0] im, output bit emitted,
                                          output row_sum_t res);
    logic signed [63:0] cr, ci, vr, vi;
    int unsigned        span, idx, fill;
    emitted = 1'b0;
    res     = '0;
    vr = {{32{re[31]}}, re};
    vi = {{32{im[31]}}, im};
    if (f == FUNC_LOAD) begin
      fill = (top + 1) * (top + 1);
      if (ld_ptr < fill) begin
        coef_re[ld_ptr] = re;
        coef_im[ld_ptr] = im;
        written[ld_ptr] = 1'b1;
        ld_ptr++;
        effective_items++;
      end
      return;
    end
    effective_items++;
    span = 2 * deg_cnt + 1;
    idx  = base + col_cnt;
    cr = {{32{coef_re[idx][31]}}, coef_re[idx]};
    ci = {{32{coef_im[idx][31]}}, coef_im[idx]};
    acc_re = acc_add(acc_re, cr * vr);
    acc_re = acc_add(acc_re, -(ci * vi));
    acc_im = acc_add(acc_im, cr * vi);
    acc_im = acc_add(acc_im, ci * vr);
    col_cnt++;
    if (col_cnt < span) return;
    emitted  = 1'b1;
    res.re   = to_q16(acc_re);
    res.im   = to_q16(acc_im);
    res.deg  = deg_cnt[DEG_OUT_W-1:0];
    res.ord  = row_cnt[ORD_OUT_W-1:0];
    res.last = (deg_cnt >= top) && (row_cnt + 1 >= span);
    acc_re  = '0;
    acc_im  = '0;
    col_cnt = 0;
    row_cnt++;
    if (row_cnt >= span) begin
      row_cnt = 0;
      base    += span;
      deg_cnt++;
    end
    if (res.last) begin
      row_cnt     = 0;
      deg_cnt     = 0;
      base        = 0;
      ld_ptr      = 0;
      pass_closed = 1'b1;
    end
  endfunction

  function automatic logic [31:0] pick_value(input bit is_coef);
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0: r = 32'h7FFF_FFFF;
          1: r = 32'h8000_0000;
          2: r = 32'h0000_0000;
          3: r = 32'hFFFF_FFFF;
          4: r = 32'h4000_0000;
          default: r = 32'hC000_0000;
        endcase
      end
      1, 2: ;
      default: r = is_coef ? {{10{r[21]}}, r[21:0]} : {{2{r[29]}}, r[29:0]};
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("[%0t] MISMATCH %s: got %h, want %h", $time, what, got, want);
  endtask

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input func_t f, input logic [31:0] re, input logic [31:0] im,
                           input bit typed, input row_sum_t want);
    int       gap;
    bit       emitted;
    row_sum_t got;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    func     <= f;
    value_re <= re;
    value_im <= im;
    do @(posedge clk); while (!in_ready);
    items_taken++;
    burst_left--;
    accumulate_item(f, re, im, emitted, got);
    if (emitted) row_sums.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  // Element unless a load is asked for or its coefficient is still unwritten; then a load is sent.
  task automatic send_random(input bit as_load);
    bit    do_load;
    func_t f;
    do_load = as_load || !written[base + col_cnt];
    f = FUNC_ELEM;
    if (do_load) f = FUNC_LOAD;
    send_item(f, pick_value(do_load), pick_value(do_load), 1'b0, '0);
  endtask

  // Drain the block, then write the register while nothing is in flight.
  task automatic set_top_degree(input int unsigned t);
    in_valid <= 1'b0;
    while (row_sums.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= TOP_W'(t);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    top = t;
  endtask

  task automatic plan_item(input func_t f, input logic [31:0] re, input logic [31:0] im);
    plan_row_t r;
    r = '{is_cfg: 1'b0, f: f, re: re, im: im, typed: 1'b0, want: '0};
    plan.push_back(r);
  endtask

  task automatic plan_check(input func_t f, input logic [31:0] re, input logic [31:0] im,
                            input logic [31:0] wre, input logic [31:0] wim,
                            input int wdeg, input int word, input bit wlast);
    plan_row_t r;
    r = '{is_cfg: 1'b0, f: f, re: re, im: im, typed: 1'b1, want: '0};
    r.want = '{re: wre, im: wim, deg: wdeg[DEG_OUT_W-1:0], ord: word[ORD_OUT_W-1:0],
               last: wlast};
    plan.push_back(r);
  endtask

  task automatic plan_top(input int t);
    plan_row_t r;
    r = '{is_cfg: 1'b1, f: FUNC_LOAD, re: t, im: '0, typed: 1'b0, want: '0};
    plan.push_back(r);
  endtask

  always @(posedge clk) begin : check_results
    row_sum_t want;
    if (!rst && out_valid && out_ready) begin
      if (row_sums.size() == 0) begin
        report_mismatch("result with nothing pending, sym_re", sym_re, '0);
      end else begin
        want = row_sums.pop_front();
        if (sym_re !== want.re) report_mismatch("sym_re", sym_re, want.re);
        if (sym_im !== want.im) report_mismatch("sym_im", sym_im, want.im);
        if (degree !== want.deg) report_mismatch("degree", degree, want.deg);
        if (order_index !== want.ord) report_mismatch("order_index", order_index, want.ord);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  // Result side: rotating stall patterns plus long hold-offs that back up the input.
  initial begin : receiver
    int cyc;
    int mode;
    cyc       = 0;
    mode      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst && items_taken >= hold_mark) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_mark += 700;
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      cyc++;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= (cyc % 4 == 0);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int unsigned t_next, fill, n_pre, trunc_at, n_elem, cap;
    bit          full;
    int          r;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    func        = FUNC_LOAD;
    value_re    = '0;
    value_im    = '0;

    // Top degree 0 out of reset: one coefficient, one element per pass.
    plan_item(FUNC_LOAD, 32'h0001_0000, 32'h0000_0000);
    plan_check(FUNC_ELEM, 32'h4000_0000, 32'h0000_0000,
               32'h0001_0000, 32'h0000_0000, 0, 0, 1'b1);
    plan_item(FUNC_LOAD, 32'h7FFF_FFFF, 32'h8000_0000);
    plan_item(FUNC_LOAD, 32'h1234_5678, 32'h9ABC_DEF0);   // past the count: dropped
    plan_check(FUNC_ELEM, 32'h7FFF_FFFF, 32'h0000_0000,
               32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 1'b1);
    plan_top(2);
    repeat (4) plan_item(FUNC_LOAD, 32'h8000_0000, 32'h8000_0000);
    repeat (5) plan_item(FUNC_LOAD, 32'h0003_0000, 32'hFFFD_0000);
    plan_item(FUNC_ELEM, 32'h8000_0000, 32'h7FFF_FFFF);
    // Lower the top degree mid-pass: the degree 1 block now closes the pass.
    plan_top(0);
    repeat (2) plan_item(FUNC_ELEM, 32'h8000_0000, 32'h7FFF_FFFF);
    plan_check(FUNC_ELEM, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h0000_0006, 1, 0, 1'b0);
    plan_item(FUNC_LOAD, 32'hDEAD_BEEF, 32'h0000_0000);  // count reached: dropped
    repeat (2) plan_item(FUNC_ELEM, 32'h4000_0000, 32'h0000_0000);
    plan_check(FUNC_ELEM, 32'h4000_0000, 32'h0000_0000,
               32'h8000_0000, 32'h8000_0000, 1, 1, 1'b0);
    repeat (2) plan_item(FUNC_ELEM, 32'h0000_0000, 32'h0000_0001);
    plan_check(FUNC_ELEM, 32'h0000_0000, 32'h0000_0001,
               32'h0000_0006, 32'hFFFF_FFFA, 1, 2, 1'b1);

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_top_degree(plan[i].re);
      else send_item(plan[i].f, plan[i].re, plan[i].im, plan[i].typed, plan[i].want);
    end

    effective_items = 0;
    for (int p = 0; effective_items < RANDOM_ITEMS; p++) begin
      if (p == 0) begin
        t_next = 15;
      end else begin
        r = $urandom_range(0, 15);
        t_next = (r < 11) ? $urandom_range(0, 3) :
                 (r < 14) ? $urandom_range(4, 6) : $urandom_range(7, 15);
      end
      if (t_next != top) set_top_degree(t_next);
      fill  = (t_next + 1) * (t_next + 1);
      full  = (t_next > 6) || ($urandom_range(0, 3) != 0);
      n_pre = full ? fill : $urandom_range(0, fill);
      if (full && $urandom_range(0, 2) == 0) n_pre += $urandom_range(1, 3);
      // Big and some other full passes may be cut short by lowering the top degree once idle.
      trunc_at = (full && (t_next > 6 || $urandom_range(0, 9) == 0)) ?
                 $urandom_range(1, 80) : 0;
      repeat (n_pre) send_random(1'b1);
      n_elem      = 0;
      pass_closed = 1'b0;
      while (!pass_closed) begin
        if (trunc_at != 0 && n_elem == trunc_at) begin
          cap = (deg_cnt + 1 < top) ? deg_cnt + 1 : top;
          set_top_degree($urandom_range(0, cap));
          trunc_at = 0;
        end
        if ($urandom_range(0, 11) == 0) begin
          send_random(1'b1);
        end else begin
          send_random(1'b0);
          n_elem++;
        end
      end
    end

    in_valid <= 1'b0;
    while (row_sums.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
